/* rtl/bea_pkg.sv */
// Shared types and constants of the button edge and auto-repeat block.
package bea_pkg;

  localparam int IDX_W  = 7;
  localparam int TICK_W = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_BUTTONS_DEFAULT = 128;
  localparam int TIMER_BITS_DEFAULT  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 1'd1;

  localparam logic [CFG_W-1:0] FIRST_DELAY_RESET     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RESET = 16'd100;

  typedef struct packed {
    logic [IDX_W-1:0]  button_index;
    logic              is_down;
    logic [TICK_W-1:0] elapsed_ticks;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] which_button;
    logic             held;
    logic             pressed;
    logic             released;
    logic             repeat_fire;
  } out_word_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic repeat_fire;
  } flags_t;

endpackage

/* rtl/bea_chan_if.sv */
// Valid/ready channel that carries one word of a given type.
interface bea_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bea_state_mem.sv */
// Per-button state memory with a clearing sweep after reset.
module bea_state_mem #(
  parameter int NUM_BUTTONS = bea_pkg::NUM_BUTTONS_DEFAULT,
  parameter int ADDR_W      = 7,
  parameter int ENTRY_W     = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  output logic               busy
);
  import bea_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BUTTONS - 1);

  logic [ENTRY_W-1:0] mem [NUM_BUTTONS];
  logic [ADDR_W-1:0]  clear_addr;

  // The sweep writes zero to one entry per cycle until the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      clear_addr <= '0;
    end else if (busy) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == LAST_ADDR) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* rtl/bea_update.sv */
// Next-state and flag logic for one button sample.
module bea_update #(
  parameter int TIMER_BITS = bea_pkg::TIMER_BITS_DEFAULT,
  parameter int ENTRY_W    = TIMER_BITS + 2
) (
  input  logic                      in_range,
  input  logic                      is_down,
  input  logic [bea_pkg::TICK_W-1:0] elapsed_ticks,
  input  logic [bea_pkg::CFG_W-1:0]  first_delay,
  input  logic [bea_pkg::CFG_W-1:0]  repeat_interval,
  input  logic [ENTRY_W-1:0]        entry,
  output logic [ENTRY_W-1:0]        entry_next,
  output bea_pkg::flags_t           flags
);
  import bea_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  prev;
  logic                  steady;
  logic [TIMER_BITS-1:0] count;
  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] count_sat;
  logic [CFG_W-1:0]      limit;
  logic                  expire;
  logic                  steady_next;
  logic [TIMER_BITS-1:0] count_next;

  assign prev   = entry[ENTRY_W-1];
  assign steady = entry[TIMER_BITS];
  assign count  = entry[TIMER_BITS-1:0];

  // The timer sticks at all ones instead of wrapping.
  assign sum       = {1'b0, count} + (TIMER_BITS+1)'(elapsed_ticks);
  assign count_sat = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
  assign limit     = steady ? repeat_interval : first_delay;
  assign expire    = CMP_W'(count_sat) >= CMP_W'(limit);

  always_comb begin
    steady_next = steady;
    count_next  = count;
    flags       = '0;
    if (in_range) begin
      if (is_down) begin
        if (!prev) begin
          flags.pressed     = 1'b1;
          flags.repeat_fire = 1'b1;
          steady_next       = 1'b0;
        end else if (expire) begin
          flags.repeat_fire = 1'b1;
          count_next        = '0;
          steady_next       = 1'b1;
        end else begin
          count_next = count_sat;
        end
      end else begin
        flags.released = prev;
        count_next     = '0;
      end
    end
  end

  assign entry_next = {is_down, steady_next, count_next};
endmodule

/* rtl/button_edge_autorepeat.sv */
// Top level of the button edge detector with typematic auto-repeat.
//
//   Channel   Dir  Word type    Content
//   sample    in   in_word_t    button_index, is_down, elapsed_ticks
//   result    out  out_word_t   which_button, held, pressed, released, repeat_fire
//   cfg_*     in   -            write port: 0 = first_delay, 1 = repeat_interval
//
// One sample word is taken per cycle unless the sweep or a stall holds it; it goes to
// the update stage, then to the result register. The state memory is read at acceptance;
// the update, the write-back and the result register load all happen when the update
// stage moves on. After reset the state memory is cleared in a sweep; no sample is taken
// meanwhile, while configuration writes are taken as usual. A result stall holds the
// result register and the update stage, and a full update stage shuts the sample side.
module button_edge_autorepeat #(
  parameter int NUM_BUTTONS = bea_pkg::NUM_BUTTONS_DEFAULT,
  parameter int TIMER_BITS  = bea_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  bea_chan_if.sink                      sample,
  bea_chan_if.source                    result,
  input  logic                          cfg_write,
  input  logic [bea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bea_pkg::CFG_W-1:0]     cfg_data
);
  import bea_pkg::*;

  localparam int ADDR_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int ENTRY_W = TIMER_BITS + 2;

  // Configuration registers.
  logic [CFG_W-1:0] first_delay;
  logic [CFG_W-1:0] repeat_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay     <= FIRST_DELAY_RESET;
      repeat_interval <= REPEAT_INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_DELAY:     first_delay     <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake control. The update stage moves on whenever the result register
  // is empty or is being emptied in this cycle.
  logic busy;
  logic s1_valid;
  logic out_valid;
  logic out_free;
  logic s1_advance;
  logic accept;

  assign out_free     = !out_valid || result.ready;
  assign s1_advance   = s1_valid && out_free;
  assign sample.ready = !busy && (!s1_valid || out_free);
  assign accept       = sample.valid && sample.ready;

  // Update stage holds the sample whose state read is in flight.
  in_word_t          s1_word;
  logic              s1_in_range;
  logic [ADDR_W-1:0] s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word     <= sample.data;
      s1_in_range <= 32'(sample.data.button_index) < NUM_BUTTONS;
    end
  end

  assign s1_addr = ADDR_W'(s1_word.button_index);

  // State memory.
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] entry_next;
  logic               wr_en;

  assign wr_en = s1_advance && s1_in_range;

  bea_state_mem #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .ADDR_W      (ADDR_W),
    .ENTRY_W     (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(sample.data.button_index)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (entry_next),
    .busy    (busy)
  );

  // The write of the previous sample lands on the same edge as the read of the
  // next one, so the read misses it. The bypass register always holds the most
  // recent write, which is also what the memory holds for that address.
  logic               byp_valid;
  logic [ADDR_W-1:0]  byp_addr;
  logic [ENTRY_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (wr_en) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr <= s1_addr;
      byp_data <= entry_next;
    end
  end

  assign entry = (byp_valid && byp_addr == s1_addr) ? byp_data : rd_data;

  flags_t flags;

  bea_update #(
    .TIMER_BITS (TIMER_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_update (
    .in_range        (s1_in_range),
    .is_down         (s1_word.is_down),
    .elapsed_ticks   (s1_word.elapsed_ticks),
    .first_delay     (first_delay),
    .repeat_interval (repeat_interval),
    .entry           (entry),
    .entry_next      (entry_next),
    .flags           (flags)
  );

  // Result register.
  out_word_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_word.which_button <= s1_word.button_index;
      out_word.held         <= s1_word.is_down;
      out_word.pressed      <= flags.pressed;
      out_word.released     <= flags.released;
      out_word.repeat_fire  <= flags.repeat_fire;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

endmodule

/* rtl/bea_checker.sv */
// Port-level checks of the button edge block and their binding to the top level.
module bea_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_ready,
  input logic               result_valid,
  input logic               result_ready,
  input bea_pkg::out_word_t result_data
);
  import bea_pkg::*;

  // The clearing sweep keeps the sample channel closed right after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !sample_ready)
    else $error("sample channel open during the clearing sweep");

  // A press always fires and is only seen on a held button.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.pressed |-> result_data.held && result_data.repeat_fire)
    else $error("press without held level or fire");

  // A button that is up never fires and never shows a press.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.held |-> !result_data.pressed && !result_data.repeat_fire)
    else $error("press or fire on a released button");

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result word changed while stalled");
endmodule

bind button_edge_autorepeat bea_checker u_bea_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

/* tb/tb_button_edge_autorepeat.sv */
// Self-checking testbench for the button edge detector with typematic auto-repeat.
`timescale 1ns / 100ps

module tb_button_edge_autorepeat;
  import bea_pkg::*;

  localparam int NBTN = NUM_BUTTONS_DEFAULT;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bea_chan_if #(.word_t(in_word_t)) sample_ch ();
  bea_chan_if #(.word_t(out_word_t)) result_ch ();

  button_edge_autorepeat u_top (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the per-button state and of the two limit registers. It is
  // advanced at the clock edge where a sample word is accepted, so the queue
  // below always holds the result words in the order the block must emit them.
  logic        last_level [NBTN];
  logic [15:0] hold_ticks [NBTN];
  logic        in_repeat  [NBTN];
  logic [CFG_W-1:0] delay_cfg;
  logic [CFG_W-1:0] interval_cfg;

  out_word_t expected_q [$];

  int mismatches;
  int samples_sent;
  int results_checked;
  int settings_used;

  // Traffic shaping: percent of cycles the sender idles and the receiver
  // stalls, plus a long hold-off of the receiver counted down in cycles.
  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is bounded by a fixed time far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void clear_shadow_state();
    for (int b = 0; b < NBTN; b++) begin
      last_level[b] = 1'b0;
      hold_ticks[b] = '0;
      in_repeat[b]  = 1'b0;
    end
    delay_cfg    = FIRST_DELAY_RESET;
    interval_cfg = REPEAT_INTERVAL_RESET;
  endfunction

  // Computes the result word for one sample and advances the shadow state.
  // The index field is 7 bits wide and the block holds 128 buttons, so every
  // index addresses a real button.
  function automatic out_word_t predict_sample(input in_word_t w);
    out_word_t r;
    int unsigned b;
    logic [16:0] sum;
    logic [15:0] limit_v;
    b = 32'(w.button_index);
    r.which_button = w.button_index;
    r.held         = w.is_down;
    r.pressed      = 1'b0;
    r.released     = 1'b0;
    r.repeat_fire  = 1'b0;
    if (w.is_down) begin
      if (!last_level[b]) begin
        // A press fires at once and restarts the first-delay wait; the elapsed
        // ticks of the press sample are not counted and the timer is left alone.
        r.pressed     = 1'b1;
        r.repeat_fire = 1'b1;
        in_repeat[b]  = 1'b0;
      end else begin
        sum = {1'b0, hold_ticks[b]} + {9'd0, w.elapsed_ticks};
        if (sum[16]) begin
          sum = 17'h0FFFF;
        end
        limit_v = in_repeat[b] ? interval_cfg : delay_cfg;
        if (sum[15:0] >= limit_v) begin
          r.repeat_fire = 1'b1;
          sum           = '0;
          in_repeat[b]  = 1'b1;
        end
        hold_ticks[b] = sum[15:0];
      end
    end else begin
      // An up sample clears the timer but keeps the repeat phase.
      if (last_level[b]) begin
        r.released = 1'b1;
      end
      hold_ticks[b] = '0;
    end
    last_level[b] = w.is_down;
    return r;
  endfunction

  // Register writes only happen while the block is idle. The wait after
  // lowering the enable keeps two writes in a row from touching cfg_write
  // twice in one time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx,
                           input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (reg_idx == REG_FIRST_DELAY) begin
      delay_cfg = value;
    end else begin
      interval_cfg = value;
    end
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] delay_v,
                            input logic [CFG_W-1:0] interval_v);
    write_reg(REG_FIRST_DELAY, delay_v);
    write_reg(REG_REPEAT_INTERVAL, interval_v);
    settings_used++;
  endtask

  // Offers one sample word and returns at the edge where it is taken. Valid is
  // left high on return, so back-to-back words keep it asserted.
  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic down,
                             input logic [TICK_W-1:0] ticks);
    in_word_t w;
    w.button_index  = idx;
    w.is_down       = down;
    w.elapsed_ticks = ticks;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= w;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    expected_q.push_back(predict_sample(w));
    samples_sent++;
  endtask

  // Stops offering and waits until every predicted word has come back; a further
  // wait then covers the two-stage pipeline.
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int got, input int exp_v,
                             input int btn);
    if (got != exp_v) begin
      report_mismatch($sformatf("button %0d field %s: got %0d, expected %0d",
                                btn, name, got, exp_v));
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t exp_w;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result word for button %0d with no sample pending",
                                got.which_button));
      return;
    end
    exp_w = expected_q.pop_front();
    results_checked++;
    check_field("which_button", int'(got.which_button), int'(exp_w.which_button),
                int'(exp_w.which_button));
    check_field("held", int'(got.held), int'(exp_w.held), int'(exp_w.which_button));
    check_field("pressed", int'(got.pressed), int'(exp_w.pressed),
                int'(exp_w.which_button));
    check_field("released", int'(got.released), int'(exp_w.released),
                int'(exp_w.which_button));
    check_field("repeat_fire", int'(got.repeat_fire), int'(exp_w.repeat_fire),
                int'(exp_w.which_button));
  endtask

  // Result side: checks each accepted word, then decides ready for the next
  // cycle. A pending hold-off wins over the random stall.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        check_result(result_ch.data);
      end
      if (recv_hold_left > 0) begin
        result_ch.ready <= 1'b0;
        recv_hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Reset values of both limits: the first repeat after 500 held ticks, then
  // every 100. Edges on idle buttons and a re-press that must restart the
  // first-delay wait are covered too.
  task automatic test_reset_defaults();
    send_sample(7'd0, 1'b0, 8'd7);      // up while already up: no release
    send_sample(7'd0, 1'b1, 8'd200);    // press: ticks ignored
    send_sample(7'd0, 1'b1, 8'd255);
    send_sample(7'd64, 1'b1, 8'd0);     // another button pressed in between
    send_sample(7'd0, 1'b1, 8'd244);    // 499 ticks held: not yet
    send_sample(7'd0, 1'b1, 8'd1);      // 500: first repeat
    send_sample(7'd0, 1'b1, 8'd99);
    send_sample(7'd0, 1'b1, 8'd1);      // 100 in the steady phase: repeat
    send_sample(7'd0, 1'b1, 8'd0);
    send_sample(7'd64, 1'b0, 8'd255);
    send_sample(7'd0, 1'b0, 8'd255);    // release clears the timer
    send_sample(7'd0, 1'b0, 8'd0);
    send_sample(7'd0, 1'b1, 8'd3);      // re-press goes back to the first delay
    send_sample(7'd0, 1'b1, 8'd255);
    send_sample(7'd0, 1'b1, 8'd255);    // 510: fires on the first delay again
    send_sample(7'd127, 1'b1, 8'd255);
    send_sample(7'd127, 1'b1, 8'd255);
    send_sample(7'd127, 1'b0, 8'd128);
    wait_idle();
  endtask

  // Both limits at zero: every held sample after the press fires.
  task automatic test_zero_limits();
    set_limits(16'd0, 16'd0);
    send_sample(7'd3, 1'b1, 8'd85);
    send_sample(7'd3, 1'b1, 8'd0);
    send_sample(7'd3, 1'b1, 8'd0);
    send_sample(7'd3, 1'b1, 8'd255);
    send_sample(7'd3, 1'b0, 8'd0);
    send_sample(7'd3, 1'b0, 8'd170);
    wait_idle();
  endtask

  // Both limits at their maximum: the timer has to clamp at all ones before
  // it can reach the limit, and it fires on the clamped value.
  task automatic test_timer_saturation();
    set_limits(16'hFFFF, 16'hFFFF);
    send_sample(7'd9, 1'b1, 8'd0);
    send_sample(7'd9, 1'b1, 8'd1);
    for (int k = 0; k < 257; k++) begin
      send_sample(7'd9, 1'b1, 8'd255);
    end
    send_sample(7'd9, 1'b1, 8'd255);
    send_sample(7'd9, 1'b0, 8'd0);
    wait_idle();
  endtask

  // Picks the next sample. Most words follow a few buttons with sticky levels
  // so that long holds and repeat chains build up; the rest is noise on any
  // button with any level.
  task automatic send_random_sample(input logic [IDX_W-1:0] pool [6]);
    logic [IDX_W-1:0] idx;
    logic down;
    logic [TICK_W-1:0] ticks;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      idx  = IDX_W'($urandom_range(NBTN - 1));
      down = 1'($urandom_range(1));
    end else begin
      idx = pool[$urandom_range(5)];
      if (last_level[idx]) begin
        down = ($urandom_range(99) >= 8);
      end else begin
        down = ($urandom_range(99) < 40);
      end
    end
    roll = $urandom_range(9);
    if (roll < 4) begin
      ticks = TICK_W'($urandom_range(15));
    end else if (roll < 8) begin
      ticks = TICK_W'($urandom_range(255));
    end else begin
      ticks = 8'hFF;
    end
    send_sample(idx, down, ticks);
  endtask

  task automatic test_random_phase(input int n_items, input logic [CFG_W-1:0] delay_v,
                                   input logic [CFG_W-1:0] interval_v,
                                   input int idle_pct, input int stall_pct);
    logic [IDX_W-1:0] pool [6];
    for (int k = 0; k < 6; k++) begin
      pool[k] = IDX_W'($urandom_range(NBTN - 1));
    end
    set_limits(delay_v, interval_v);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      send_random_sample(pool);
    end
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the pipeline fills and the sample channel has to stall.
  // Afterwards the sender pauses until every word has drained.
  task automatic test_output_holdoff();
    logic [IDX_W-1:0] pool [6];
    for (int k = 0; k < 6; k++) begin
      pool[k] = IDX_W'($urandom_range(NBTN - 1));
    end
    set_limits(16'd20, 16'd10);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = 200;
    for (int k = 0; k < 40; k++) begin
      send_random_sample(pool);
    end
    wait_idle();
  endtask

  initial begin
    int waited;
    mismatches      = 0;
    samples_sent    = 0;
    results_checked = 0;
    settings_used   = 1;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    recv_hold_left  = 0;
    clear_shadow_state();

    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_FIRST_DELAY;
    cfg_data        <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks first, with no random idling on either side. The block's
    // clearing sweep after reset is absorbed by waiting for ready.
    test_reset_defaults();
    test_zero_limits();
    test_timer_saturation();
    test_output_holdoff();

    // Random phases: no idling, a mostly idle sender, a mostly stalling
    // receiver, then light idling on both sides.
    test_random_phase(195, CFG_W'($urandom_range(600)), CFG_W'($urandom_range(150)),
                      0, 0);
    test_random_phase(195, 16'd0, CFG_W'($urandom_range(400)), 79, 0);
    test_random_phase(195, CFG_W'($urandom_range(1500)), 16'd0, 0, 79);
    test_random_phase(195, CFG_W'($urandom_range(3000)), CFG_W'($urandom_range(500)),
                      17, 17);

    sample_ch.valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", expected_q.size()));
    end

    $display("Run covered %0d samples and %0d result words under %0d limit settings,",
             samples_sent, results_checked, settings_used);
    $display("including zero limits, timer saturation and a long output hold-off.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
